[hw/rtl/rpn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN operand stack package
// Action and status codes, controller states, command struct and the widths
// shared by the operand stack modules.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DefStackDepth = 16;
  localparam int DefWordBits   = 64;

  localparam int ActionW   = 4;
  localparam int ValueW    = 64;
  localparam int StatusW   = 2;
  localparam int FillOutW  = 5;
  localparam int InDataW   = 64;
  localparam int InUserW   = 4;
  // popped, top, second, fill level, padded to whole bytes
  localparam int OutFieldW = 3 * ValueW + FillOutW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int OutUserW  = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH       = 4'd0,
    ACT_POP        = 4'd1,
    ACT_DROP       = 4'd2,
    ACT_DUP        = 4'd3,
    ACT_SWAP       = 4'd4,
    ACT_CLEAR      = 4'd5,
    ACT_ROLL_DOWN  = 4'd6,
    ACT_ROLL_UP    = 4'd7,
    ACT_CLEAR_TOP  = 4'd8,
    ACT_PUSH_LASTX = 4'd9,
    ACT_UNARY      = 4'd10,
    ACT_BINARY     = 4'd11
  } rpn_action_e;

  typedef enum logic [StatusW-1:0] {
    STS_DONE    = 2'd0,
    STS_FEW     = 2'd1,
    STS_IGNORED = 2'd2,
    STS_LOST    = 2'd3
  } rpn_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } rpn_state_e;

  typedef struct packed {
    logic load_in;  // capture the accepted action and word
    logic exec;     // apply the action and load the result register
  } rpn_cmd_t;

endpackage

[hw/rtl/rpn_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN operand stack controller
// Two-state sequencer: take one action, then apply it once the result
// register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rpn_pkg::rpn_cmd_t cmd_o
);
  import rpn_pkg::*;

  rpn_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       in_fire;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_fire;
      end
      ST_EXEC: begin
        // hold the action while the previous result is still pending
        cmd_o.exec = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/rpn_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN operand stack datapath
// Shifting cell array with the top in cell 0, fill count, last-x register
// and the registered result.
// ----------------------------------------------------------------------------
module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::DefStackDepth,
  parameter int WORD_BITS   = rpn_pkg::DefWordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpn_pkg::rpn_cmd_t             cmd_i,
  input  logic [rpn_pkg::ActionW-1:0]   action_i,
  input  logic [rpn_pkg::ValueW-1:0]    value_i,
  output logic [rpn_pkg::StatusW-1:0]   status_o,
  output logic [rpn_pkg::ValueW-1:0]    popped_word_o,
  output logic [rpn_pkg::ValueW-1:0]    top_word_o,
  output logic [rpn_pkg::ValueW-1:0]    second_word_o,
  output logic [rpn_pkg::FillOutW-1:0]  fill_level_o
);
  import rpn_pkg::*;

  localparam int FillW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW  = $clog2(STACK_DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;

  function automatic logic [ValueW-1:0] widen(input word_t w);
    logic [ValueW-1:0] r;
    r = '0;
    r[WORD_BITS-1:0] = w;
    return r;
  endfunction

  word_t            cells_q [STACK_DEPTH];
  word_t            cells_d [STACK_DEPTH];
  logic [FillW-1:0] occ_q, occ_d;
  word_t            lastx_q, lastx_d;
  rpn_action_e      act_q;
  word_t            val_q;

  logic [FillW-1:0] occ_m1;
  logic [IdxW-1:0]  bot_idx;
  logic             is_empty, is_full, has_two;
  word_t            push_word;
  word_t            popped_d;
  rpn_status_e      status_d;

  logic [StatusW-1:0]   status_q;
  logic [ValueW-1:0]    popped_q, top_q, second_q;
  logic [FillW+4:0]     fill_ext;
  logic [FillOutW-1:0]  fill_q;

  assign occ_m1    = occ_q - FillW'(1);
  assign bot_idx   = occ_m1[IdxW-1:0];
  assign is_empty  = (occ_q == '0);
  assign is_full   = (occ_q == FillW'(STACK_DEPTH));
  assign has_two   = (occ_q >= FillW'(2));
  assign push_word = (act_q == ACT_PUSH_LASTX) ? lastx_q : val_q;

  always_comb begin
    cells_d  = cells_q;
    occ_d    = occ_q;
    lastx_d  = lastx_q;
    popped_d = '0;
    status_d = STS_DONE;
    case (act_q)
      ACT_PUSH, ACT_PUSH_LASTX: begin
        // a full stack drops its bottom cell off the far end
        for (int k = STACK_DEPTH - 1; k > 0; k--) cells_d[k] = cells_q[k-1];
        cells_d[0] = push_word;
        if (is_full) status_d = STS_LOST;
        else occ_d = occ_q + FillW'(1);
      end
      ACT_POP, ACT_DROP: begin
        if (!is_empty) begin
          if (act_q == ACT_POP) popped_d = cells_q[0];
          for (int k = 0; k < STACK_DEPTH - 1; k++) cells_d[k] = cells_q[k+1];
          occ_d = occ_m1;
        end else begin
          status_d = STS_FEW;
        end
      end
      ACT_DUP: begin
        if (!is_empty && !is_full) begin
          for (int k = STACK_DEPTH - 1; k > 0; k--) cells_d[k] = cells_q[k-1];
          occ_d = occ_q + FillW'(1);
        end else begin
          status_d = STS_IGNORED;
        end
      end
      ACT_SWAP: begin
        if (has_two) begin
          cells_d[0] = cells_q[1];
          cells_d[1] = cells_q[0];
        end else begin
          status_d = STS_IGNORED;
        end
      end
      ACT_CLEAR: begin
        occ_d = '0;
      end
      ACT_ROLL_DOWN: begin
        if (has_two) begin
          for (int k = 0; k < STACK_DEPTH; k++) begin
            if (k < int'(bot_idx)) cells_d[k] = cells_q[(k + 1) % STACK_DEPTH];
            else if (k == int'(bot_idx)) cells_d[k] = cells_q[0];
          end
        end else begin
          status_d = STS_IGNORED;
        end
      end
      ACT_ROLL_UP: begin
        if (has_two) begin
          cells_d[0] = cells_q[bot_idx];
          for (int k = 1; k < STACK_DEPTH; k++) begin
            if (k <= int'(bot_idx)) cells_d[k] = cells_q[k-1];
          end
        end else begin
          status_d = STS_IGNORED;
        end
      end
      ACT_CLEAR_TOP: begin
        if (!is_empty) cells_d[0] = '0;
        else status_d = STS_IGNORED;
      end
      ACT_UNARY: begin
        if (!is_empty) begin
          lastx_d    = cells_q[0];
          cells_d[0] = val_q;
        end else begin
          status_d = STS_FEW;
        end
      end
      ACT_BINARY: begin
        if (has_two) begin
          lastx_d = cells_q[0];
          for (int k = 1; k < STACK_DEPTH - 1; k++) cells_d[k] = cells_q[k+1];
          cells_d[0] = val_q;
          occ_d      = occ_m1;
        end else begin
          status_d = STS_FEW;
        end
      end
      default: begin
        status_d = STS_IGNORED;
      end
    endcase
  end

  assign fill_ext = {5'b0, occ_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      lastx_q <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) cells_q[k] <= '0;
    end else if (cmd_i.exec) begin
      occ_q   <= occ_d;
      lastx_q <= lastx_d;
      cells_q <= cells_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q <= rpn_action_e'(action_i);
      val_q <= value_i[WORD_BITS-1:0];
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      popped_q <= widen(popped_d);
      top_q    <= (occ_d >= FillW'(1)) ? widen(cells_d[0]) : '0;
      second_q <= (occ_d >= FillW'(2)) ? widen(cells_d[1]) : '0;
      fill_q   <= fill_ext[FillOutW-1:0];
    end
  end

  assign status_o      = status_q;
  assign popped_word_o = popped_q;
  assign top_word_o    = top_q;
  assign second_word_o = second_q;
  assign fill_level_o  = fill_q;

endmodule

[hw/rtl/rpn_operand_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN operand stack
// Bounded calculator operand stack with last-x register, push-on-full
// shifting, rolls and externally computed replace actions.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                         tuser
//  s_axis    in         value                         action
//  m_axis    out        popped, top, second, fill     status
//
//  An action is captured in the idle state, then applied to the shifting
//  cell array in the exec state, which also loads the result register;
//  the exec state waits while an earlier result is still pending.
//  A new action is taken while a result still waits; it is applied only
//  once that result has been transferred.
//  Reset clears every cell, the fill count and last-x; no clearing pass.
// ----------------------------------------------------------------------------
module rpn_operand_stack #(
  parameter int STACK_DEPTH = rpn_pkg::DefStackDepth,
  parameter int WORD_BITS   = rpn_pkg::DefWordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rpn_pkg::InDataW-1:0]   s_axis_tdata,   // [63:0] value
  input  logic [rpn_pkg::InUserW-1:0]   s_axis_tuser,   // [3:0] action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] popped_word, [127:64] top_word, [191:128] second_word,
  // [196:192] fill_level, upper bits zero
  output logic [rpn_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [rpn_pkg::OutUserW-1:0]  m_axis_tuser    // [1:0] status
);
  import rpn_pkg::*;

  rpn_cmd_t             cmd;
  logic [StatusW-1:0]   status;
  logic [ValueW-1:0]    popped_word, top_word, second_word;
  logic [FillOutW-1:0]  fill_level;

  rpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (s_axis_tuser),
    .value_i       (s_axis_tdata),
    .status_o      (status),
    .popped_word_o (popped_word),
    .top_word_o    (top_word),
    .second_word_o (second_word),
    .fill_level_o  (fill_level)
  );

  assign m_axis_tdata = {{(OutDataW - OutFieldW){1'b0}},
                         fill_level, second_word, top_word, popped_word};
  assign m_axis_tuser = status;

endmodule

[hw/rtl/rpn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN operand stack checker
// Port-level properties of the operand stack, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker #(
  parameter int STACK_DEPTH = rpn_pkg::DefStackDepth
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rpn_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [rpn_pkg::OutUserW-1:0]  m_axis_tuser
);
  import rpn_pkg::*;

  localparam bit FillExact = (STACK_DEPTH < 32);

  logic [FillOutW-1:0] fill;
  logic [ValueW-1:0]   popped, top, second;

  assign popped = m_axis_tdata[ValueW-1:0];
  assign top    = m_axis_tdata[2*ValueW-1:ValueW];
  assign second = m_axis_tdata[3*ValueW-1:2*ValueW];
  assign fill   = m_axis_tdata[3*ValueW+FillOutW-1:3*ValueW];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // the controller is busy for the cycle after a transfer in
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && FillExact |-> fill <= FillOutW'(STACK_DEPTH))
    else $error("fill level beyond stack depth");

  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && FillExact && fill == '0 |-> top == '0 && second == '0)
    else $error("empty stack reports nonzero words");

  a_lost_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && FillExact && m_axis_tuser == STS_LOST |->
      fill == FillOutW'(STACK_DEPTH) && popped == '0)
    else $error("lost-bottom status without a full stack");

endmodule

bind rpn_operand_stack rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_checker (.*);
